### rtl/core/mfhp_pkg.sv
// Package for the 802.15.4 MAC header parser: field widths, frame and address
// mode codes, verdict codes and the header offset helpers.
// No dependencies.
`default_nettype none

package mfhp_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 127;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned HDR_W     = 5;
    localparam int unsigned DLEN_W    = 7;
    localparam int unsigned VERDICT_W = 4;

    localparam logic [15:0] ALL16         = 16'hFFFF;
    localparam logic [15:0] OWN_PAN_RESET = 16'h4447;
    localparam logic [7:0]  BYTE_ONES     = 8'hFF;

    // Frame type field, bits 2:0 of frame control.
    localparam logic [2:0] FT_BEACON = 3'd0;
    localparam logic [2:0] FT_DATA   = 3'd1;
    localparam logic [2:0] FT_ACK    = 3'd2;

    // Addressing modes.
    localparam logic [1:0] AM_NONE  = 2'd0;
    localparam logic [1:0] AM_RSVD  = 2'd1;
    localparam logic [1:0] AM_SHORT = 2'd2;
    localparam logic [1:0] AM_LONG  = 2'd3;

    // Verdict codes.
    localparam logic [3:0] V_ACCEPT   = 4'd0;
    localparam logic [3:0] V_SHORT    = 4'd1;
    localparam logic [3:0] V_RSVD_BIT = 4'd2;
    localparam logic [3:0] V_SEQ_SUPP = 4'd3;
    localparam logic [3:0] V_IE       = 4'd4;
    localparam logic [3:0] V_DST_MODE = 4'd5;
    localparam logic [3:0] V_SRC_MODE = 4'd6;
    localparam logic [3:0] V_BEACON   = 4'd7;
    localparam logic [3:0] V_ACK      = 4'd8;
    localparam logic [3:0] V_OTHER    = 4'd9;
    localparam logic [3:0] V_PAN_MISS = 4'd10;
    localparam logic [3:0] V_TRUNC    = 4'd11;
    localparam logic [3:0] V_OVERSIZE = 4'd12;

    localparam logic [DLEN_W-1:0] DLEN_MAX = 7'd127;

    // Byte offset of the source address, given the destination mode and broadcast flag.
    function automatic logic [HDR_W-1:0] src_start(input logic [1:0] dmode,
                                                   input logic       bcast);
        logic [HDR_W-1:0] s;
        case (dmode)
            AM_SHORT: s = bcast ? 5'd9 : 5'd7;
            AM_LONG:  s = 5'd13;
            default:  s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic logic [HDR_W-1:0] src_len(input logic [1:0] smode);
        logic [HDR_W-1:0] n;
        case (smode)
            AM_SHORT: n = 5'd2;
            AM_LONG:  n = 5'd8;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mfhp_if.sv
// Channel interfaces of the MAC header parser: frame byte input, verdict
// output and the own-PAN configuration write. Depends on mfhp_pkg.
`default_nettype none

interface mfhp_in_if;
    import mfhp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface mfhp_out_if;
    import mfhp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [HDR_W-1:0]     hdr_len;
    logic [DLEN_W-1:0]    payload_len;
    logic [15:0]          pan_id;
    logic [15:0]          dst_short;
    logic [15:0]          src_short;
    logic [63:0]          dst_long;
    logic [63:0]          src_long;
    logic                 is_broadcast;
    logic [7:0]           seq_num;

    modport source (output valid, output verdict, output hdr_len,
                    output payload_len, output pan_id, output dst_short,
                    output src_short, output dst_long, output src_long,
                    output is_broadcast, output seq_num, input ready);
    modport sink   (input valid, input verdict, input hdr_len,
                    input payload_len, input pan_id, input dst_short,
                    input src_short, input dst_long, input src_long,
                    input is_broadcast, input seq_num, output ready);
endinterface

interface mfhp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] own_pan;

    modport source (output valid, output own_pan, input ready);
    modport sink   (input valid, input own_pan, output ready);
endinterface

`default_nettype wire

### rtl/core/mac_frame_header_parser.sv
// Top level of the 802.15.4 MAC header parser: byte capture, header checks
// and verdict output. Depends on mfhp_pkg and the interfaces in mfhp_if.sv.
//
//   Port       Dir  Beat carries
//   frame_in   in   frame_byte, frame_last (one frame byte, FCS included)
//   result_out out  verdict, lengths, PAN, addresses, broadcast, sequence
//   cfg        in   own_pan (PAN that data frames must carry)
//
// One frame byte is taken every cycle unless ready is low; a beat is held in the
// input register and is then folded into the header state, and on a last byte
// into the output register, which offers the verdict. Ready drops only when a
// last byte waits while a previous verdict has not yet been taken. Reset clears
// all frame state and loads own_pan with 0x4447; cfg is always ready.
`default_nettype none

module mac_frame_header_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    mfhp_in_if.sink   frame_in,
    mfhp_out_if.source result_out,
    mfhp_cfg_if.sink  cfg
);
    import mfhp_pkg::*;

    // Input register.
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Frame state.
    logic [POS_W-1:0] pos_reg;
    logic             over_reg;
    logic [15:0]      fc_reg;
    logic [7:0]       seq_reg;
    logic [15:0]      pan_reg;
    logic [15:0]      dst_short_reg;
    logic [15:0]      src_short_reg;
    logic [63:0]      dst_long_reg;
    logic [63:0]      src_long_reg;
    logic             bcast_reg;
    logic [15:0]      own_pan_reg;

    // Output register.
    logic                 out_vld_reg;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [HDR_W-1:0]     hlen_reg, hlen_next;
    logic [DLEN_W-1:0]    dlen_reg, dlen_next;
    logic [15:0]          opan_reg, opan_next;
    logic [15:0]          odst_s_reg, odst_s_next;
    logic [15:0]          osrc_s_reg, osrc_s_next;
    logic [63:0]          odst_l_reg, odst_l_next;
    logic [63:0]          osrc_l_reg, osrc_l_next;
    logic                 obc_reg, obc_next;
    logic [7:0]           oseq_reg, oseq_next;

    logic out_free, proc, accept, finish;

    // Capture results for the beat in the input register.
    logic [POS_W-1:0] pos_c;
    logic             over_now, over_c;
    logic [15:0]      fc_c, pan_c, dst_short_c, src_short_c;
    logic [7:0]       seq_c;
    logic [63:0]      dst_long_c, src_long_c;
    logic             bc_c;
    logic [HDR_W-1:0] s_start, s_len, he;
    logic [POS_W-1:0] s_off, s_beg, s_end, dl_idx;
    logic [8:0]       dl9;

    assign out_free = !out_vld_reg || result_out.ready;
    assign proc     = in_vld_reg && (!in_last_reg || out_free);
    assign finish   = proc && in_last_reg;
    assign frame_in.ready = !in_vld_reg || proc;
    assign accept   = frame_in.valid && frame_in.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (proc)
            in_vld_next = 1'b0;
    end

    // Byte capture, following the header layout implied by frame control.
    always_comb
    begin
        over_now    = pos_reg >= POS_W'(MAX_FRAME_BYTES);
        fc_c        = fc_reg;
        seq_c       = seq_reg;
        pan_c       = pan_reg;
        dst_short_c = dst_short_reg;
        src_short_c = src_short_reg;
        dst_long_c  = dst_long_reg;
        src_long_c  = src_long_reg;
        bc_c        = bcast_reg;
        dl_idx      = pos_reg - POS_W'(5);
        s_start     = src_start(fc_reg[11:10], bcast_reg);
        s_len       = src_len(fc_reg[15:14]);
        s_beg       = '0;
        s_end       = '0;
        s_off       = '0;
        if (!over_now)
        begin
            case (pos_reg)
                8'd0: fc_c[7:0]  = in_byte_reg;
                8'd1: fc_c[15:8] = in_byte_reg;
                8'd2: seq_c      = in_byte_reg;
                default:
                begin
                    if (fc_reg[2:0] == FT_DATA)
                    begin
                        if (fc_reg[11:10] == AM_SHORT || fc_reg[11:10] == AM_LONG)
                        begin
                            if (pos_reg == 8'd3)
                                pan_c[7:0] = in_byte_reg;
                            if (pos_reg == 8'd4)
                                pan_c[15:8] = in_byte_reg;
                        end
                        if (fc_reg[11:10] == AM_SHORT)
                        begin
                            if (pos_reg == 8'd5)
                                dst_short_c[7:0] = in_byte_reg;
                            if (pos_reg == 8'd6)
                            begin
                                dst_short_c[15:8] = in_byte_reg;
                                if (pan_reg == ALL16 && dst_short_reg[7:0] == BYTE_ONES
                                    && in_byte_reg == BYTE_ONES)
                                    bc_c = 1'b1;
                            end
                            // Broadcast frames carry the source PAN after dst.
                            if (bc_c && pos_reg == 8'd7)
                                pan_c[7:0] = in_byte_reg;
                            if (bc_c && pos_reg == 8'd8)
                                pan_c[15:8] = in_byte_reg;
                        end
                        else if (fc_reg[11:10] == AM_LONG)
                        begin
                            if (pos_reg >= 8'd5 && pos_reg <= 8'd12)
                                dst_long_c[{dl_idx[2:0], 3'b000} +: 8] = in_byte_reg;
                        end
                        s_start = src_start(fc_reg[11:10], bc_c);
                        s_beg   = {3'b000, s_start};
                        s_end   = {3'b000, s_start + s_len};
                        s_off   = pos_reg - s_beg;
                        if (pos_reg >= s_beg && pos_reg < s_end)
                        begin
                            if (fc_reg[15:14] == AM_SHORT)
                                src_short_c[{s_off[0], 3'b000} +: 8] = in_byte_reg;
                            else
                                src_long_c[{s_off[2:0], 3'b000} +: 8] = in_byte_reg;
                        end
                    end
                end
            endcase
        end
        pos_c  = over_now ? pos_reg : pos_reg + POS_W'(1);
        over_c = over_reg || over_now;
        he     = src_start(fc_c[11:10], bc_c) + src_len(fc_c[15:14]);
        dl9    = {1'b0, pos_c} - {4'b0000, he} - 9'd2;
    end

    // Verdict, in the order the checks take precedence.
    always_comb
    begin
        verdict_next = V_ACCEPT;
        hlen_next    = '0;
        dlen_next    = '0;
        opan_next    = '0;
        odst_s_next  = '0;
        osrc_s_next  = '0;
        odst_l_next  = '0;
        osrc_l_next  = '0;
        obc_next     = 1'b0;
        oseq_next    = '0;
        if (over_c)
            verdict_next = V_OVERSIZE;
        else if (pos_c < POS_W'(2))
            verdict_next = V_SHORT;
        else if (fc_c[7])
            verdict_next = V_RSVD_BIT;
        else if (fc_c[8])
            verdict_next = V_SEQ_SUPP;
        else if (fc_c[9])
            verdict_next = V_IE;
        else if (fc_c[2:0] == FT_BEACON)
            verdict_next = V_BEACON;
        else if (fc_c[2:0] == FT_ACK)
        begin
            verdict_next = V_ACK;
            oseq_next    = seq_c;
        end
        else if (fc_c[2:0] != FT_DATA)
            verdict_next = V_OTHER;
        else if (fc_c[11:10] == AM_RSVD)
            verdict_next = V_DST_MODE;
        else if (fc_c[15:14] == AM_RSVD)
            verdict_next = V_SRC_MODE;
        else if ({1'b0, pos_c} < {4'b0000, he} + 9'd2)
        begin
            verdict_next = V_TRUNC;
            hlen_next    = he;
        end
        else
        begin
            verdict_next = (pan_c == own_pan_reg) ? V_ACCEPT : V_PAN_MISS;
            hlen_next    = he;
            dlen_next    = (dl9 > 9'(DLEN_MAX)) ? DLEN_MAX : dl9[DLEN_W-1:0];
            opan_next    = pan_c;
            odst_s_next  = dst_short_c;
            osrc_s_next  = src_short_c;
            odst_l_next  = bc_c ? {64{1'b1}} : dst_long_c;
            osrc_l_next  = src_long_c;
            obc_next     = bc_c;
            oseq_next    = seq_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            own_pan_reg <= OWN_PAN_RESET;
            pos_reg       <= '0;
            over_reg      <= 1'b0;
            fc_reg        <= '0;
            seq_reg       <= '0;
            pan_reg       <= '0;
            dst_short_reg <= '0;
            src_short_reg <= '0;
            dst_long_reg  <= '0;
            src_long_reg  <= '0;
            bcast_reg     <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg.valid)
                own_pan_reg <= cfg.own_pan;
            if (finish)
                out_vld_reg <= 1'b1;
            else if (result_out.ready)
                out_vld_reg <= 1'b0;
            if (finish)
            begin
                pos_reg       <= '0;
                over_reg      <= 1'b0;
                fc_reg        <= '0;
                seq_reg       <= '0;
                pan_reg       <= '0;
                dst_short_reg <= '0;
                src_short_reg <= '0;
                dst_long_reg  <= '0;
                src_long_reg  <= '0;
                bcast_reg     <= 1'b0;
            end
            else if (proc)
            begin
                pos_reg       <= pos_c;
                over_reg      <= over_c;
                fc_reg        <= fc_c;
                seq_reg       <= seq_c;
                pan_reg       <= pan_c;
                dst_short_reg <= dst_short_c;
                src_short_reg <= src_short_c;
                dst_long_reg  <= dst_long_c;
                src_long_reg  <= src_long_c;
                bcast_reg     <= bc_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= frame_in.frame_byte;
            in_last_reg <= frame_in.frame_last;
        end
        if (finish)
        begin
            verdict_reg <= verdict_next;
            hlen_reg    <= hlen_next;
            dlen_reg    <= dlen_next;
            opan_reg    <= opan_next;
            odst_s_reg  <= odst_s_next;
            osrc_s_reg  <= osrc_s_next;
            odst_l_reg  <= odst_l_next;
            osrc_l_reg  <= osrc_l_next;
            obc_reg     <= obc_next;
            oseq_reg    <= oseq_next;
        end
    end

    assign result_out.valid        = out_vld_reg;
    assign result_out.verdict      = verdict_reg;
    assign result_out.hdr_len      = hlen_reg;
    assign result_out.payload_len  = dlen_reg;
    assign result_out.pan_id       = opan_reg;
    assign result_out.dst_short    = odst_s_reg;
    assign result_out.src_short    = osrc_s_reg;
    assign result_out.dst_long     = odst_l_reg;
    assign result_out.src_long     = osrc_l_reg;
    assign result_out.is_broadcast = obc_reg;
    assign result_out.seq_num      = oseq_reg;

    // A last beat always leaves the frame state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (pos_reg == '0 && !over_reg && !bcast_reg))
        else $error("frame state not cleared after last beat");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position beyond frame limit");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(finish))
        else $error("verdict without a last beat");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> verdict_reg <= V_OVERSIZE)
        else $error("verdict code out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !result_out.ready) |-> !finish)
        else $error("pending verdict overwritten");

endmodule

`default_nettype wire
